[rtl/swsd_pkg.sv]
// swsd_pkg: shared sizes, codes and types of the split work-stealing deque
// depends on nothing; used by every module of the block but swsd_ram by scoped names
`timescale 1ns / 1ps
`default_nettype none

package swsd_pkg;

    localparam int DEPTH    = 1024;
    localparam int HANDLE_W = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    typedef logic [ADDR_W-1:0]   t_idx;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_idx IDX_ONE  = t_idx'(1);
    localparam t_idx IDX_LAST = t_idx'(DEPTH - 1);

    localparam t_func FUNC_PUSH   = 2'd0;
    localparam t_func FUNC_POP    = 2'd1;
    localparam t_func FUNC_STEAL  = 2'd2;
    localparam t_func FUNC_EXPOSE = 2'd3;

    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_JOB      = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_PRIVATE  = 3'd3;
    localparam t_status ST_OVERFLOW = 3'd4;

    // slot access and answer for one operation
    typedef struct packed {
        logic    ram_en;
        logic    ram_we;
        t_idx    addr;
        t_status status;
        logic    targeted;
    } t_op;

endpackage

`default_nettype wire

[rtl/swsd_ram.sv]
// swsd_ram: generic single-port synchronous ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module swsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/swsd_ctrl.sv]
// swsd_ctrl: top, public-bottom and bottom pointers, targeted mark, and the
// per-operation decision; depends on swsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module swsd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire swsd_pkg::t_func  i_func,
    output swsd_pkg::t_op         o_op
);

    swsd_pkg::t_idx r_bot, r_pub, r_top;
    swsd_pkg::t_idx n_bot, n_pub, n_top;
    logic           r_targeted, n_targeted;
    swsd_pkg::t_idx pub_m1;
    swsd_pkg::t_op  op;

    assign pub_m1 = r_pub - swsd_pkg::IDX_ONE;

    always_comb begin
        n_bot       = r_bot;
        n_pub       = r_pub;
        n_top       = r_top;
        n_targeted  = r_targeted;
        op.ram_en   = 1'b0;
        op.ram_we   = 1'b0;
        op.addr     = r_bot;
        op.status   = swsd_pkg::ST_DONE;
        unique case (i_func)
            swsd_pkg::FUNC_PUSH: begin
                if (r_bot >= swsd_pkg::IDX_LAST) begin
                    op.status = swsd_pkg::ST_OVERFLOW;
                end else begin
                    op.ram_en  = 1'b1;
                    op.ram_we  = 1'b1;
                    n_bot      = r_bot + swsd_pkg::IDX_ONE;
                    n_targeted = 1'b0;
                end
            end
            swsd_pkg::FUNC_POP: begin
                if (r_bot > r_pub) begin
                    n_bot     = r_bot - swsd_pkg::IDX_ONE;
                    op.ram_en = 1'b1;
                    op.addr   = n_bot;
                    op.status = swsd_pkg::ST_JOB;
                end else if (r_pub <= swsd_pkg::IDX_ONE) begin
                    n_bot      = swsd_pkg::IDX_ONE;
                    n_pub      = swsd_pkg::IDX_ONE;
                    n_top      = swsd_pkg::IDX_ONE;
                    n_targeted = 1'b1;
                    op.status  = swsd_pkg::ST_EMPTY;
                end else if (pub_m1 > r_top) begin
                    n_bot      = pub_m1;
                    n_pub      = pub_m1;
                    n_targeted = 1'b0;
                    op.ram_en  = 1'b1;
                    op.addr    = pub_m1;
                    op.status  = swsd_pkg::ST_JOB;
                end else begin
                    n_bot = swsd_pkg::IDX_ONE;
                    n_pub = swsd_pkg::IDX_ONE;
                    n_top = swsd_pkg::IDX_ONE;
                    if (pub_m1 == r_top) begin
                        n_targeted = 1'b0;
                        op.ram_en  = 1'b1;
                        op.addr    = pub_m1;
                        op.status  = swsd_pkg::ST_JOB;
                    end else begin
                        n_targeted = 1'b1;
                        op.status  = swsd_pkg::ST_EMPTY;
                    end
                end
            end
            swsd_pkg::FUNC_STEAL: begin
                if (r_pub > r_top) begin
                    op.ram_en  = 1'b1;
                    op.addr    = r_top;
                    op.status  = swsd_pkg::ST_JOB;
                    n_top      = r_top + swsd_pkg::IDX_ONE;
                    n_targeted = 1'b0;
                end else if (r_pub < r_bot) begin
                    op.status = swsd_pkg::ST_PRIVATE;
                end else begin
                    op.status = swsd_pkg::ST_EMPTY;
                end
            end
            swsd_pkg::FUNC_EXPOSE: begin
                if (r_pub < r_bot) begin
                    n_pub = r_pub + swsd_pkg::IDX_ONE;
                end
            end
            default: begin
                op.status = swsd_pkg::ST_DONE;
            end
        endcase
        op.targeted = n_targeted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot      <= swsd_pkg::IDX_ONE;
            r_pub      <= swsd_pkg::IDX_ONE;
            r_top      <= swsd_pkg::IDX_ONE;
            r_targeted <= 1'b0;
        end else if (i_accept) begin
            r_bot      <= n_bot;
            r_pub      <= n_pub;
            r_top      <= n_top;
            r_targeted <= n_targeted;
        end
    end

    assign o_op = op;

endmodule

`default_nettype wire

[rtl/split_work_stealing_deque.sv]
// split_work_stealing_deque: top level, slot ram, pending stage and output register
// depends on swsd_pkg, swsd_ctrl and swsd_ram
// a result passes the slot ram read and pending stage, then the output register
// throughput: one request per cycle unless stalled; pointers update at transfer
// slot ram has one port; a full output register stalls the pending stage and input
// reset clears pointers to 1, targeted mark and valid flags; slot contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module split_work_stealing_deque (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_func,
    input  wire logic [31:0]               i_job_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [31:0]                    o_job_out,
    output logic [2:0]                     o_status,
    output logic                           o_targeted_flag
);

    swsd_pkg::t_op     op;
    swsd_pkg::t_handle rd_data;
    logic              accept;
    logic              advance;

    logic              r_pend_valid;
    swsd_pkg::t_status r_pend_status;
    logic              r_pend_targeted;

    logic              r_out_valid;
    swsd_pkg::t_handle r_out_job;
    swsd_pkg::t_status r_out_status;
    logic              r_out_targeted;

    assign advance    = r_pend_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    swsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (i_func),
        .o_op     (op)
    );

    swsd_ram #(
        .WIDTH (swsd_pkg::HANDLE_W),
        .DEPTH (swsd_pkg::DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_en      (accept && op.ram_en),
        .i_we      (op.ram_we),
        .i_addr    (op.addr),
        .i_wr_data (i_job_in),
        .o_rd_data (rd_data)
    );

    // pending stage waits for the slot read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (accept) begin
            r_pend_valid <= 1'b1;
        end else if (advance) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_status   <= op.status;
            r_pend_targeted <= op.targeted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_job      <= (r_pend_status == swsd_pkg::ST_JOB) ? rd_data : '0;
            r_out_status   <= r_pend_status;
            r_out_targeted <= r_pend_targeted;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_job_out       = r_out_job;
    assign o_status        = r_out_status;
    assign o_targeted_flag = r_out_targeted;

endmodule

`default_nettype wire

[rtl/swsd_checker.sv]
// swsd_checker: port-level assertions for the deque, bound to the top level
// depends on swsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module swsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_job_out,
    input wire logic [2:0]  o_status,
    input wire logic        o_targeted_flag
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_job_out)
            && $stable(o_status) && $stable(o_targeted_flag))
        else $error("stalled result changed");

    // no job handle without a job status
    a_job_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != swsd_pkg::ST_JOB |-> o_job_out == '0)
        else $error("job handle without job status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= swsd_pkg::ST_OVERFLOW)
        else $error("status code out of range");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("valid after reset");

    // no result without a request: while input and output stay idle, no result appears
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && o_in_ready) ##1 !o_out_valid
            && !(i_in_valid && o_in_ready) |=> !o_out_valid)
        else $error("result without request");

endmodule

bind split_work_stealing_deque swsd_checker u_swsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_job_out       (o_job_out),
    .o_status        (o_status),
    .o_targeted_flag (o_targeted_flag)
);

`default_nettype wire

[test/tb_split_work_stealing_deque.sv]
// tb_split_work_stealing_deque: self-checking bench for the split work-stealing deque
// a scoreboard class predicts each answer; tasks drive requests in bursts, the sink stalls
// depends on swsd_pkg and split_work_stealing_deque
`timescale 1ns / 1ps

typedef struct packed {
    swsd_pkg::t_handle job;
    swsd_pkg::t_status status;
    logic              targeted;
} t_deque_answer;

class deque_scoreboard;
    swsd_pkg::t_handle slot_mem [swsd_pkg::DEPTH];
    int unsigned       bot_ptr;
    int unsigned       pub_ptr;
    int unsigned       top_ptr;
    bit                targeted;
    t_deque_answer     answer_q[$];
    int unsigned       errors;

    function new();
        bot_ptr  = 1;
        pub_ptr  = 1;
        top_ptr  = 1;
        targeted = 1'b0;
        errors   = 0;
    endfunction

    function void clear_pointers();
        bot_ptr = 1;
        pub_ptr = 1;
        top_ptr = 1;
    endfunction

    function int unsigned pending();
        return answer_q.size();
    endfunction

    // predict the answer of one request transfer
    function void note_request(swsd_pkg::t_func op, swsd_pkg::t_handle handle);
        t_deque_answer ans;
        ans.job    = '0;
        ans.status = swsd_pkg::ST_DONE;
        case (op)
            swsd_pkg::FUNC_PUSH: begin
                if (bot_ptr >= swsd_pkg::DEPTH - 1) begin
                    ans.status = swsd_pkg::ST_OVERFLOW;
                end else begin
                    slot_mem[bot_ptr] = handle;
                    bot_ptr++;
                    targeted = 1'b0;
                end
            end
            swsd_pkg::FUNC_POP: begin
                if (bot_ptr > pub_ptr) begin
                    bot_ptr--;
                    ans.job    = slot_mem[bot_ptr];
                    ans.status = swsd_pkg::ST_JOB;
                end else begin
                    targeted = 1'b1;
                    if (pub_ptr <= 1) begin
                        clear_pointers();
                        ans.status = swsd_pkg::ST_EMPTY;
                    end else if (pub_ptr - 1 > top_ptr) begin
                        pub_ptr--;
                        bot_ptr    = pub_ptr;
                        targeted   = 1'b0;
                        ans.job    = slot_mem[pub_ptr];
                        ans.status = swsd_pkg::ST_JOB;
                    end else if (pub_ptr - 1 == top_ptr) begin
                        ans.job    = slot_mem[top_ptr];
                        ans.status = swsd_pkg::ST_JOB;
                        targeted   = 1'b0;
                        clear_pointers();
                    end else begin
                        clear_pointers();
                        ans.status = swsd_pkg::ST_EMPTY;
                    end
                end
            end
            swsd_pkg::FUNC_STEAL: begin
                if (pub_ptr > top_ptr) begin
                    ans.job    = slot_mem[top_ptr];
                    ans.status = swsd_pkg::ST_JOB;
                    top_ptr++;
                    targeted = 1'b0;
                end else if (pub_ptr < bot_ptr) begin
                    ans.status = swsd_pkg::ST_PRIVATE;
                end else begin
                    ans.status = swsd_pkg::ST_EMPTY;
                end
            end
            default: begin
                if (pub_ptr < bot_ptr) pub_ptr++;
            end
        endcase
        ans.targeted = targeted;
        answer_q.push_back(ans);
    endfunction

    function void check_result(swsd_pkg::t_handle job, swsd_pkg::t_status status, logic flag);
        t_deque_answer exp_ans;
        if (answer_q.size() == 0) begin
            $error("unexpected result transfer: job_out %h status %0d", job, status);
            errors++;
            return;
        end
        exp_ans = answer_q.pop_front();
        if (job !== exp_ans.job) begin
            $error("job_out: expected %h, actual %h", exp_ans.job, job);
            errors++;
        end
        if (status !== exp_ans.status) begin
            $error("status: expected %0d, actual %0d", exp_ans.status, status);
            errors++;
        end
        if (flag !== exp_ans.targeted) begin
            $error("targeted_flag: expected %0b, actual %0b", exp_ans.targeted, flag);
            errors++;
        end
    endfunction
endclass

module tb_split_work_stealing_deque;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func          = swsd_pkg::FUNC_PUSH;
    logic [31:0] i_job_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [31:0] o_job_out;
    logic [2:0]  o_status;
    logic        o_targeted_flag;

    deque_scoreboard sb = new();
    int unsigned     burst_left = 0;
    int unsigned     cycle_count = 0;
    t_rx_mode        rx_mode = RX_OPEN;
    logic [7:0]      rx_tick = '0;

    split_work_stealing_deque dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_job_in        (i_job_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_job_out       (o_job_out),
        .o_status        (o_status),
        .o_targeted_flag (o_targeted_flag)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sink backpressure picks a new random mode whenever the low six bits of rx_tick are zero
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick[5:0] == 6'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     i_out_ready <= 1'b1;
            RX_LIGHT:    i_out_ready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: i_out_ready <= (rx_tick[2:0] != 3'd5);
            default:     i_out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_request(i_func, i_job_in);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_job_out, o_status, o_targeted_flag);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_item(swsd_pkg::t_func op, swsd_pkg::t_handle handle);
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_job_in   <= handle;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic pause_sender(int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic issue(swsd_pkg::t_func op, swsd_pkg::t_handle handle);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 4) != 0) pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        send_item(op, handle);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic swsd_pkg::t_handle rand_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return swsd_pkg::t_handle'(1) << $urandom_range(0, swsd_pkg::HANDLE_W - 1);
            default: return swsd_pkg::t_handle'($urandom);
        endcase
    endfunction

    function automatic swsd_pkg::t_func pick_func(int unsigned w_push, int unsigned w_pop,
                                                  int unsigned w_steal, int unsigned w_expose);
        int unsigned roll;
        roll = $urandom_range(0, w_push + w_pop + w_steal + w_expose - 1);
        if (roll < w_push) return swsd_pkg::FUNC_PUSH;
        if (roll < w_push + w_pop) return swsd_pkg::FUNC_POP;
        if (roll < w_push + w_pop + w_steal) return swsd_pkg::FUNC_STEAL;
        return swsd_pkg::FUNC_EXPOSE;
    endfunction

    task automatic run_mix(int unsigned count, int unsigned w_push, int unsigned w_pop,
                           int unsigned w_steal, int unsigned w_expose);
        repeat (count) issue(pick_func(w_push, w_pop, w_steal, w_expose), rand_handle());
    endtask

    // push until the deque is full and a few more get rejected; no pops so bottom only grows
    task automatic fill_to_overflow();
        int unsigned     pushes;
        swsd_pkg::t_func op;
        pushes = 0;
        while (pushes < swsd_pkg::DEPTH + 4) begin
            op = pick_func(80, 0, 10, 10);
            if (op == swsd_pkg::FUNC_PUSH) pushes++;
            issue(op, rand_handle());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty deque, private-only work, exposes past the private part
        send_item(swsd_pkg::FUNC_STEAL, 32'h1234_5678);
        send_item(swsd_pkg::FUNC_POP, '0);
        send_item(swsd_pkg::FUNC_EXPOSE, '0);
        send_item(swsd_pkg::FUNC_PUSH, 32'h0000_0000);
        send_item(swsd_pkg::FUNC_PUSH, 32'hFFFF_FFFF);
        send_item(swsd_pkg::FUNC_STEAL, '0);
        send_item(swsd_pkg::FUNC_EXPOSE, '0);
        send_item(swsd_pkg::FUNC_EXPOSE, '0);
        send_item(swsd_pkg::FUNC_EXPOSE, '1);
        send_item(swsd_pkg::FUNC_STEAL, '0);
        // owner takes the last public entry
        send_item(swsd_pkg::FUNC_POP, '0);
        send_item(swsd_pkg::FUNC_PUSH, 32'h8000_0000);
        send_item(swsd_pkg::FUNC_PUSH, 32'h0000_0001);
        send_item(swsd_pkg::FUNC_PUSH, 32'h7FFF_FFFF);
        send_item(swsd_pkg::FUNC_EXPOSE, '0);
        send_item(swsd_pkg::FUNC_EXPOSE, '0);
        send_item(swsd_pkg::FUNC_EXPOSE, '0);
        // owner falls back to the public bottom with several public entries
        send_item(swsd_pkg::FUNC_POP, '0);
        send_item(swsd_pkg::FUNC_STEAL, '0);
        send_item(swsd_pkg::FUNC_STEAL, '0);
        // public part drained by thieves with pointers above one
        send_item(swsd_pkg::FUNC_POP, '0);
        send_item(swsd_pkg::FUNC_PUSH, 32'h5A5A_5A5A);
        send_item(swsd_pkg::FUNC_POP, '0);
        send_item(swsd_pkg::FUNC_STEAL, '0);
        wait_for_results();

        run_mix(250, 35, 25, 25, 15);
        run_mix(150, 20, 30, 30, 20);
        wait_for_results();

        fill_to_overflow();
        run_mix(150, 5, 40, 40, 15);
        run_mix(100, 35, 25, 25, 15);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[split_work_stealing_deque.f]
rtl/swsd_pkg.sv
rtl/swsd_ram.sv
rtl/swsd_ctrl.sv
rtl/split_work_stealing_deque.sv
rtl/swsd_checker.sv
test/tb_split_work_stealing_deque.sv
